@@ rtl/gas_pkg.sv @@
// shared widths, reset values, register codes and types for the alignment score block
package gas_pkg;

    localparam int SCORE_W   = 16;
    localparam int GAP_W     = 15;
    localparam int CNT_W     = 5;
    localparam int GRID_W    = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    localparam logic [GRID_W-1:0] GRID_MAX  = {GRID_W{1'b1}};
    localparam logic [GAP_W-1:0]  GAP_RESET = GAP_W'(1638);
    localparam logic [CNT_W-1:0]  ROWS_RESET = CNT_W'(10);
    localparam logic [CNT_W-1:0]  COLS_RESET = CNT_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP  = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [GAP_W-1:0] gap;
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic              last;
        logic [GRID_W-1:0] grid;
    } t_core_out;

endpackage

@@ rtl/gas_cfg.sv @@
// configuration register file: gap penalty and grid dimensions
module gas_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [gas_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [gas_pkg::CFG_DAT_W-1:0]  i_data,
    output logic                           o_ready,
    output gas_pkg::t_cfg                  o_cfg
);
    import gas_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap  <= GAP_RESET;
            r_cfg.rows <= ROWS_RESET;
            r_cfg.cols <= COLS_RESET;
        end else if (i_valid) begin
            unique case (i_index)
                CFG_GAP:  r_cfg.gap  <= i_data[GAP_W-1:0];
                CFG_ROWS: r_cfg.rows <= i_data[CNT_W-1:0];
                CFG_COLS: r_cfg.cols <= i_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/gas_core.sv @@
// grid cell update: row store, left and diagonal values, position counters
module gas_core #(
    parameter int MAX_ROWS = gas_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gas_pkg::DEF_MAX_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic signed [gas_pkg::SCORE_W-1:0] i_score,
    input  gas_pkg::t_cfg                      i_cfg,
    output gas_pkg::t_core_out                 o_out
);
    import gas_pkg::*;

    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CC_W   = $clog2(MAX_COLS + 1);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int CAND_W = GRID_W + 3;

    logic [GRID_W-1:0] r_row_store [MAX_COLS];
    logic [GRID_W-1:0] r_left;
    logic [GRID_W-1:0] r_diag;
    logic [CI_W-1:0]   r_col;
    logic [RI_W-1:0]   r_row;

    logic [CC_W-1:0]          ncols;
    logic [RC_W-1:0]          nrows;
    logic                     last_col;
    logic                     last_row;
    logic [GRID_W-1:0]        up;
    logic [GRID_W-1:0]        max_lu;
    logic signed [CAND_W-1:0] cand;
    logic [GRID_W-1:0]        grid_val;

    // zero counts act as one, counts above the grid size saturate
    always_comb begin
        if (i_cfg.cols == '0) begin
            ncols = CC_W'(1);
        end else if (32'(i_cfg.cols) > MAX_COLS) begin
            ncols = CC_W'(MAX_COLS);
        end else begin
            ncols = CC_W'(i_cfg.cols);
        end
        if (i_cfg.rows == '0) begin
            nrows = RC_W'(1);
        end else if (32'(i_cfg.rows) > MAX_ROWS) begin
            nrows = RC_W'(MAX_ROWS);
        end else begin
            nrows = RC_W'(i_cfg.rows);
        end
    end

    assign last_col = (CC_W'(r_col) + CC_W'(1)) >= ncols;
    assign last_row = (RC_W'(r_row) + RC_W'(1)) >= nrows;

    assign up     = (r_row == '0) ? '0 : r_row_store[r_col];
    assign max_lu = (r_left > up) ? r_left : up;
    assign cand   = $signed({3'b000, r_diag}) + CAND_W'(i_score)
                  - $signed({{(CAND_W-GAP_W){1'b0}}, i_cfg.gap});

    always_comb begin
        if (cand > $signed({3'b000, max_lu})) begin
            if (cand > $signed({3'b000, GRID_MAX})) begin
                grid_val = GRID_MAX;
            end else begin
                grid_val = cand[GRID_W-1:0];
            end
        end else begin
            grid_val = max_lu;
        end
    end

    assign o_out.grid = grid_val;
    assign o_out.last = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                r_row_store[i] <= '0;
            end
            r_left <= '0;
            r_diag <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_adv) begin
            r_row_store[r_col] <= grid_val;
            if (last_col) begin
                r_col  <= '0;
                r_left <= '0;
                r_diag <= '0;
                if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + RI_W'(1);
                end
            end else begin
                r_col  <= r_col + CI_W'(1);
                r_left <= grid_val;
                r_diag <= up;
            end
        end
    end

endmodule

@@ rtl/gapless_alignment_score.sv @@
// Gapless alignment score: streams a signed Q1.14 score matrix in row-major
// order and returns the bottom-right grid value in unsigned Q5.14.
// Input channel: i_valid / o_stall with i_score; a request is taken when
// i_valid is high and o_stall is low. One cell can be taken every cycle while o_stall is low.
// Output channel: o_valid / i_stall with o_alignment_score; one result per
// alignment, after its last cell (rows_in_use x cols_in_use cells).
// Path: a cell sits in the input register while its grid update is done; the
// result of the last cell of an alignment is registered into the output buffer
// and is offered from there on o_alignment_score.
// Throughput is one cell per cycle while o_stall is low; the grid update
// (one add, one subtract, a three-way max) is combinational and feeds the next cell.
// Configuration: write index 0 gap penalty, 1 rows, 2 columns; o_cfg_ready
// is always high. Write only while no request or result is in flight.
// Reset clears the grid state, the position and both result valid flags and
// loads the default configuration. While the receiver stalls, results queue
// in a two-entry output buffer and cells that do not end an alignment still
// flow; the input stalls only when a last cell finds both entries full, so
// o_stall never follows i_stall within the same cycle.
module gapless_alignment_score #(
    parameter int MAX_ROWS = gas_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gas_pkg::DEF_MAX_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [gas_pkg::SCORE_W-1:0] i_score,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gas_pkg::GRID_W-1:0]         o_alignment_score,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gas_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import gas_pkg::*;

    t_cfg                     cfg;
    t_core_out                core_out;
    logic                     r_in_valid;
    logic signed [SCORE_W-1:0] r_in_score;
    logic                     r_out_valid;
    logic [GRID_W-1:0]        r_out_score;
    logic                     r_skid_valid;
    logic [GRID_W-1:0]        r_skid_score;
    logic                     adv;
    logic                     in_acc;
    logic                     out_take;
    logic                     push_res;

    gas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    gas_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_score (r_in_score),
        .i_cfg   (cfg),
        .o_out   (core_out)
    );

    // a last cell waits only while both result registers are occupied
    assign adv      = r_in_valid && (!core_out.last || !r_skid_valid);
    assign o_stall  = r_in_valid && !adv;
    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign push_res = adv && core_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_score <= i_score;
        end
    end

    // head drives the port, the second entry catches a result behind a stalled head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= r_skid_valid || push_res;
            end
            r_skid_valid <= (r_skid_valid || push_res) && r_out_valid && !out_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_score <= r_skid_valid ? r_skid_score : core_out.grid;
        end
        if (push_res && r_out_valid && !out_take) begin
            r_skid_score <= core_out.grid;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_alignment_score = r_out_score;

endmodule

@@ rtl/gas_checker.sv @@
// port-level checks for the alignment score block and their bind
module gas_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic signed [gas_pkg::SCORE_W-1:0] i_score,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [gas_pkg::GRID_W-1:0]         o_alignment_score,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready
);

    // the input only backs up behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_alignment_score)))
        else $error("stalled result dropped or changed");

    // a stalled request is held by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_score)))
        else $error("stalled request dropped or changed");

    // the configuration port never pushes back
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration request refused");

endmodule

bind gapless_alignment_score gas_checker u_gas_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for the gapless alignment score block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gas_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_CELLS   = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PLAN_LEN       = 29;

    typedef enum {STEP_WRITE, STEP_CELL} t_step;

    typedef struct {
        t_step                  kind;
        logic [CFG_IDX_W-1:0]   sel;
        logic [CFG_DAT_W-1:0]   wdata;
        logic signed [SCORE_W-1:0] score;
        bit                     known;
        logic [GRID_W-1:0]      corner;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [SCORE_W-1:0] i_score;
    logic                      o_valid;
    logic                      i_stall;
    logic [GRID_W-1:0]         o_alignment_score;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DAT_W-1:0]      i_cfg_data;

    // grid predictor state and its copy of the registers
    logic [19:0]       grid_prev_row [DEF_MAX_COLS];
    logic [19:0]       grid_left;
    logic [19:0]       grid_diag;
    int                grid_row_pos;
    int                grid_col_pos;
    logic [GAP_W-1:0]  cur_gap;
    logic [CNT_W-1:0]  cur_rows;
    logic [CNT_W-1:0]  cur_cols;

    logic [GRID_W-1:0] pending_corners [$];
    t_plan_row         directed_plan [PLAN_LEN];
    int                mismatches = 0;
    bit                fast_mode = 1'b0;
    bit                hold_req = 1'b0;
    int                recv_wait = 3;
    int                recv_hold = 0;
    int                random_cells = 0;

    gapless_alignment_score i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_score           (i_score),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_alignment_score (o_alignment_score),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #6ns i_clk = 1'b1;
        #6ns i_clk = 1'b0;
    end

    function automatic int count_limit(input logic [CNT_W-1:0] v, input int top);
        if (v == 0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function automatic void fill_grid_cell(input logic signed [SCORE_W-1:0] s,
                                           output bit done,
                                           output logic [GRID_W-1:0] corner);
        int nr;
        int nc;
        int up;
        int cand;
        int best;
        nr = count_limit(cur_rows, DEF_MAX_ROWS);
        nc = count_limit(cur_cols, DEF_MAX_COLS);
        up = (grid_row_pos == 0) ? 0 : int'(grid_prev_row[grid_col_pos]);
        cand = int'(grid_diag) + int'(s) - int'(cur_gap);
        best = int'(grid_left);
        if (up > best) best = up;
        if (cand > best) best = cand;
        if (best > int'(GRID_MAX)) best = int'(GRID_MAX);
        grid_prev_row[grid_col_pos] = 20'(best);
        grid_diag = 20'(up);
        grid_left = 20'(best);
        done = 1'b0;
        corner = '0;
        if (grid_col_pos + 1 >= nc) begin
            grid_col_pos = 0;
            grid_left = '0;
            grid_diag = '0;
            if (grid_row_pos + 1 >= nr) begin
                grid_row_pos = 0;
                done = 1'b1;
                corner = GRID_W'(best);
            end else begin
                grid_row_pos++;
            end
        end else begin
            grid_col_pos++;
        end
    endfunction

    function automatic logic signed [SCORE_W-1:0] draw_score();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3: return SCORE_W'($urandom);
            default: return SCORE_W'($urandom_range(0, 24000));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] draw_gap();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_DAT_W'(16384);
            2: return CFG_DAT_W'($urandom);
            3: return {CFG_DAT_W{1'b1}};
            default: return CFG_DAT_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] draw_count();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_DAT_W'(16);
            2: return CFG_DAT_W'($urandom_range(17, 31));
            3: return CFG_DAT_W'($urandom);
            4: return CFG_DAT_W'($urandom_range(5, 15));
            default: return CFG_DAT_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic log_fault(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // caller sits at a falling edge; returns at the falling edge after the request is taken
    task automatic push_cell(input logic signed [SCORE_W-1:0] s, input bit known,
                             input logic [GRID_W-1:0] known_corner);
        int idle;
        bit done;
        logic [GRID_W-1:0] corner;
        idle = fast_mode ? 0 : $urandom_range(0, 11);
        repeat (idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_score <= s;
        do @(posedge i_clk); while (o_stall);
        fill_grid_cell(s, done, corner);
        if (done)
            pending_corners.insert(pending_corners.size(), known ? known_corner : corner);
        @(negedge i_clk);
    endtask

    // registers change only with the pipeline drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DAT_W-1:0] wdata);
        i_valid <= 1'b0;
        while (pending_corners.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= wdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_GAP:  cur_gap  = wdata[GAP_W-1:0];
            CFG_ROWS: cur_rows = wdata[CNT_W-1:0];
            CFG_COLS: cur_cols = wdata[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [GRID_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            recv_wait = fast_mode ? 0 : $urandom_range(0, 11);
            if (pending_corners.size() == 0) begin
                log_fault($sformatf("unexpected alignment_score %0d", o_alignment_score));
            end else begin
                want = pending_corners.pop_front();
                if (want !== o_alignment_score)
                    log_fault($sformatf("alignment_score mismatch: expected %0d, got %0d",
                                        want, o_alignment_score));
            end
        end
    end

    // receiver stall; the per-result wait only runs down while a result is offered
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                recv_hold = HOLD_CYCLES;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                if (o_valid) recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles where no request moves on any channel
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int area;
        int n_cells;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_score     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        foreach (grid_prev_row[k]) grid_prev_row[k] = '0;
        grid_left    = '0;
        grid_diag    = '0;
        grid_row_pos = 0;
        grid_col_pos = 0;
        cur_gap      = GAP_RESET;
        cur_rows     = ROWS_RESET;
        cur_cols     = COLS_RESET;

        directed_plan = '{
            '{STEP_WRITE, CFG_ROWS,   15'd1,     16'sd0,    1'b0, 19'd0},
            '{STEP_WRITE, CFG_COLS,   15'd1,     16'sd0,    1'b0, 19'd0},
            // single-cell alignments at the default gap, then at gap zero
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh7FFF, 1'b1, 19'd31129},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh8000, 1'b1, 19'd0},
            '{STEP_WRITE, CFG_GAP,    15'd0,     16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sd0,    1'b1, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b1, 19'd16384},
            // gap above its range is used as given
            '{STEP_WRITE, CFG_GAP,    15'h7FFF,  16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh7FFF, 1'b1, 19'd0},
            // unmapped register index leaves everything alone
            '{STEP_WRITE, CFG_UNUSED, 15'h5555,  16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh7FFF, 1'b1, 19'd0},
            '{STEP_WRITE, CFG_GAP,    15'd16384, 16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh7FFF, 1'b1, 19'd16383},
            // zero counts behave as one
            '{STEP_WRITE, CFG_ROWS,   15'd0,     16'sd0,    1'b0, 19'd0},
            '{STEP_WRITE, CFG_COLS,   15'd0,     16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b1, 19'd0},
            '{STEP_WRITE, CFG_GAP,    15'd0,     16'sd0,    1'b0, 19'd0},
            '{STEP_WRITE, CFG_ROWS,   15'd2,     16'sd0,    1'b0, 19'd0},
            '{STEP_WRITE, CFG_COLS,   15'd2,     16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sh4000, 1'b1, 19'd32768},
            // shrink the column count while a row is half done
            '{STEP_WRITE, CFG_ROWS,   15'd1,     16'sd0,    1'b0, 19'd0},
            '{STEP_WRITE, CFG_COLS,   15'd4,     16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sd100,  1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     -16'sd200, 1'b0, 19'd0},
            '{STEP_WRITE, CFG_COLS,   15'd1,     16'sd0,    1'b0, 19'd0},
            '{STEP_CELL,  CFG_GAP,    15'd0,     16'sd300,  1'b0, 19'd0}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == STEP_WRITE)
                write_reg(directed_plan[k].sel, directed_plan[k].wdata);
            else
                push_cell(directed_plan[k].score, directed_plan[k].known,
                          directed_plan[k].corner);
        end

        // receiver holds off while one-cell alignments keep coming, so the block fills up
        write_reg(CFG_ROWS, CFG_DAT_W'(1));
        write_reg(CFG_COLS, CFG_DAT_W'(1));
        fast_mode = 1'b1;
        hold_req  = 1'b1;
        repeat (30) push_cell(draw_score(), 1'b0, '0);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_corners.size() != 0);
        fast_mode = 1'b0;

        while (random_cells < RANDOM_CELLS) begin
            fast_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) != 0) write_reg(CFG_GAP, draw_gap());
            if ($urandom_range(0, 1) != 0) write_reg(CFG_ROWS, draw_count());
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COLS, draw_count());
            area = count_limit(cur_rows, DEF_MAX_ROWS) * count_limit(cur_cols, DEF_MAX_COLS);
            n_cells = (area >= 64) ? area : $urandom_range(1, 3) * area;
            // sometimes stop mid-alignment so the next write lands inside one
            if ($urandom_range(0, 2) == 0) n_cells += $urandom_range(0, area - 1);
            repeat (n_cells) push_cell(draw_score(), 1'b0, '0);
            random_cells += n_cells;
        end

        i_valid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_corners.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gas_pkg.sv
rtl/gas_cfg.sv
rtl/gas_core.sv
rtl/gapless_alignment_score.sv
rtl/gas_checker.sv
tb/tb_top.sv
